/* sv/glc_pkg.sv */
// ----------------------------------------------------------------------------
// glc_pkg: shared types and constants for the grid Laplacian conduction block
// Transaction structs, register indexes, read step codes and helper functions.
// ----------------------------------------------------------------------------
package glc_pkg;

  // Grid geometry
  localparam int AXIS_MAX   = 16;
  localparam int AXIS_W     = $clog2(AXIS_MAX);
  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  // Field and datapath widths
  localparam int SIZE_W   = 5;
  localparam int WEIGHT_W = 32;
  localparam int TEMP_W   = 32;
  localparam int COND_W   = 64;
  localparam int DIFF_W   = TEMP_W + 3;
  localparam int PROD_W   = DIFF_W + WEIGHT_W + 1;
  localparam int ACC_W    = PROD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Z = 3'd5;

  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 5'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 32'd65536;

  // Operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Neighbour read order of one query
  typedef enum logic [2:0] {
    RD_CEN,
    RD_XP,
    RD_XM,
    RD_YP,
    RD_YM,
    RD_ZP,
    RD_ZM
  } rd_step_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic                     operation;
    logic [AXIS_W-1:0]        x_index;
    logic [AXIS_W-1:0]        y_index;
    logic [AXIS_W-1:0]        z_index;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [COND_W-1:0] conduction;
    logic                     out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] wx;
    logic [WEIGHT_W-1:0] wy;
    logic [WEIGHT_W-1:0] wz;
  } weights_t;

  // Accumulator control for the read data arriving this cycle
  typedef struct packed {
    logic  cen;
    logic  first;
    logic  second;
    axis_e axis;
    logic  last;
  } acc_ctl_t;

  // Size register as used: zero counts as one, large values clip to the axis
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] n;
    n = r;
    if (r == '0) begin
      n = SIZE_W'(1);
    end else if (r > SIZE_W'(AXIS_MAX)) begin
      n = SIZE_W'(AXIS_MAX);
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] point_addr(input logic [AXIS_W-1:0] x,
                                                   input logic [AXIS_W-1:0] y,
                                                   input logic [AXIS_W-1:0] z);
    return ADDR_W'({z, y, x});
  endfunction

endpackage

/* sv/glc_ram.sv */
// ----------------------------------------------------------------------------
// glc_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/glc_accum.sv */
// ----------------------------------------------------------------------------
// glc_accum: second-difference, weighting and accumulation pipeline
// Takes centre and neighbour reads, forms each axis difference, multiplies by
// the axis weight, sums the three products and saturates the negated sum.
// ----------------------------------------------------------------------------
module glc_accum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  glc_pkg::acc_ctl_t                ctl_i,
  input  logic signed [glc_pkg::TEMP_W-1:0] rd_data_i,
  input  glc_pkg::weights_t                weights_i,
  output logic                             done_o,
  output logic signed [glc_pkg::COND_W-1:0] conduction_o
);

  localparam int TW = glc_pkg::TEMP_W;
  localparam int DW = glc_pkg::DIFF_W;
  localparam int PW = glc_pkg::PROD_W;
  localparam int AW = glc_pkg::ACC_W;
  localparam int CW = glc_pkg::COND_W;
  localparam int WW = glc_pkg::WEIGHT_W;

  logic signed [TW-1:0] cen_q;
  logic signed [TW-1:0] prev_q;
  logic signed [DW-1:0] diff_q;
  logic [WW-1:0]        wgt_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic                 dv_q, dl_q, pv_q, pl_q, done_q;

  logic signed [DW-1:0] diff_d;
  logic [WW-1:0]        wgt_d;
  logic signed [PW-1:0] diff_ext;
  logic signed [PW-1:0] wgt_ext;
  logic signed [PW-1:0] prod_d;
  logic signed [AW-1:0] neg_sum;

  // Second difference: first neighbour + second neighbour - 2 * centre
  assign diff_d = {{(DW-TW){prev_q[TW-1]}}, prev_q}
                + {{(DW-TW){rd_data_i[TW-1]}}, rd_data_i}
                - {{(DW-TW-1){cen_q[TW-1]}}, cen_q, 1'b0};

  // Pick the weight of the axis being finished
  always_comb begin
    case (ctl_i.axis)
      glc_pkg::AXIS_X: wgt_d = weights_i.wx;
      glc_pkg::AXIS_Y: wgt_d = weights_i.wy;
      glc_pkg::AXIS_Z: wgt_d = weights_i.wz;
      default:         wgt_d = '0;
    endcase
  end

  // Signed difference times unsigned weight
  assign diff_ext = {{(PW-DW){diff_q[DW-1]}}, diff_q};
  assign wgt_ext  = {{(PW-WW){1'b0}}, wgt_q};
  assign prod_d   = diff_ext * wgt_ext;

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (ctl_i.cen) begin
      cen_q <= rd_data_i;
    end
    if (ctl_i.first) begin
      prev_q <= rd_data_i;
    end
    if (ctl_i.second) begin
      diff_q <= diff_d;
      wgt_q  <= wgt_d;
    end
    if (dv_q) begin
      prod_q <= prod_d;
    end
    if (ctl_i.cen) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + {{(AW-PW){prod_q[PW-1]}}, prod_q};
    end
  end

  // Stage valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= 1'b0;
      dl_q   <= 1'b0;
      pv_q   <= 1'b0;
      pl_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dv_q   <= ctl_i.second;
      dl_q   <= ctl_i.second & ctl_i.last;
      pv_q   <= dv_q;
      pl_q   <= dl_q;
      done_q <= pv_q & pl_q;
    end
  end

  // Negate and saturate to the output width
  assign neg_sum = -acc_q;

  always_comb begin
    if (neg_sum[AW-1:CW-1] == {(AW-CW+1){neg_sum[CW-1]}}) begin
      conduction_o = neg_sum[CW-1:0];
    end else if (neg_sum[AW-1]) begin
      conduction_o = {1'b1, {(CW-1){1'b0}}};
    end else begin
      conduction_o = {1'b0, {(CW-1){1'b1}}};
    end
  end

  assign done_o = done_q;

`ifndef ASSERT_OFF
  // A finished sum never coincides with new weighting work
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !pv_q && !dv_q)
    else $error("accumulator done while products still in flight");

  // After the last difference of a query, done follows through the dl, pl and done flag registers
  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.second && ctl_i.last |-> ##3 done_q)
    else $error("last axis did not complete the sum");

  // The centre is never reloaded while a query is being summed
  a_cen_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cen |-> !dv_q && !pv_q)
    else $error("centre reload during accumulation");
`endif

endmodule

/* sv/grid_laplacian_conduction_top.sv */
// ----------------------------------------------------------------------------
// grid_laplacian_conduction_top: seven-point Laplacian on a 16x16x16 grid
// Store transactions write one temperature; query transactions read the
// centre and six clamped neighbours and return the weighted conduction term.
// An in-range query reads seven points in turn on the single RAM read port, then
// passes the difference, multiply and accumulate stages; an out-of-range query goes
// straight to the result. Stores are taken one per cycle while idle; a new transaction
// is taken only after the previous result is loaded, later while the result channel stalls.
// Reset: a clearing pass zeroes the 4096 RAM entries, with in_stall_o high throughout;
// configuration writes are taken during it.
// ----------------------------------------------------------------------------
module grid_laplacian_conduction_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  glc_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output glc_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [glc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [glc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AXW = glc_pkg::AXIS_W;
  localparam int SW  = glc_pkg::SIZE_W;
  localparam int ADW = glc_pkg::ADDR_W;
  localparam int TW  = glc_pkg::TEMP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  glc_pkg::rd_step_e   step_q;
  glc_pkg::rd_step_e   rstep_q;
  logic                rvalid_q;
  logic [ADW-1:0]      clr_addr_q;
  logic                oor_q;
  logic [AXW-1:0]      x_q, y_q, z_q;
  logic                out_valid_q;
  glc_pkg::out_item_t  out_data_q;

  logic [SW-1:0]                   size_x_q, size_y_q, size_z_q;
  logic [glc_pkg::WEIGHT_W-1:0]    weight_x_q, weight_y_q, weight_z_q;

  logic [SW-1:0]       nx, ny, nz;
  logic [AXW-1:0]      xp, xm, yp, ym, zp, zm;
  logic                in_acc;
  logic                in_range;
  logic                out_free;
  logic                ram_we;
  logic [ADW-1:0]      ram_waddr;
  logic [TW-1:0]       ram_wdata;
  logic                rd_en;
  logic [ADW-1:0]      rd_addr;
  logic [TW-1:0]       rd_data;
  glc_pkg::acc_ctl_t   acc_ctl;
  glc_pkg::weights_t   weights;
  logic                acc_done;
  logic signed [glc_pkg::COND_W-1:0] acc_cond;

  function automatic logic [AXW-1:0] next_coord(input logic [AXW-1:0] c,
                                               input logic [SW-1:0]  n);
    logic [SW-1:0] c1;
    c1 = {1'b0, c} + SW'(1);
    return (c1 < n) ? c1[AXW-1:0] : c;
  endfunction

  function automatic logic [AXW-1:0] prev_coord(input logic [AXW-1:0] c);
    return (c == '0) ? c : c - AXW'(1);
  endfunction

  // Effective sizes and clamped neighbour coordinates
  assign nx = glc_pkg::eff_size(size_x_q);
  assign ny = glc_pkg::eff_size(size_y_q);
  assign nz = glc_pkg::eff_size(size_z_q);
  assign xp = next_coord(x_q, nx);
  assign yp = next_coord(y_q, ny);
  assign zp = next_coord(z_q, nz);
  assign xm = prev_coord(x_q);
  assign ym = prev_coord(y_q);
  assign zm = prev_coord(z_q);

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_range   = ({1'b0, in_data_i.x_index} < nx) &&
                      ({1'b0, in_data_i.y_index} < ny) &&
                      ({1'b0, in_data_i.z_index} < nz);

  // RAM write: clearing pass or store transaction
  assign ram_we    = (state_q == ST_CLEAR) ||
                     (in_acc && in_data_i.operation == glc_pkg::OP_STORE);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q :
                     glc_pkg::point_addr(in_data_i.x_index, in_data_i.y_index,
                                         in_data_i.z_index);
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : in_data_i.temperature;

  // RAM read: one point per read step
  assign rd_en = (state_q == ST_READ);

  always_comb begin
    case (step_q)
      glc_pkg::RD_CEN: rd_addr = glc_pkg::point_addr(x_q, y_q, z_q);
      glc_pkg::RD_XP:  rd_addr = glc_pkg::point_addr(xp, y_q, z_q);
      glc_pkg::RD_XM:  rd_addr = glc_pkg::point_addr(xm, y_q, z_q);
      glc_pkg::RD_YP:  rd_addr = glc_pkg::point_addr(x_q, yp, z_q);
      glc_pkg::RD_YM:  rd_addr = glc_pkg::point_addr(x_q, ym, z_q);
      glc_pkg::RD_ZP:  rd_addr = glc_pkg::point_addr(x_q, y_q, zp);
      glc_pkg::RD_ZM:  rd_addr = glc_pkg::point_addr(x_q, y_q, zm);
      default:         rd_addr = glc_pkg::point_addr(x_q, y_q, z_q);
    endcase
  end

  glc_ram #(
    .DATA_W (TW),
    .ADDR_W (ADW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Tag the returning read data for the accumulator
  always_comb begin
    acc_ctl        = '0;
    acc_ctl.axis   = glc_pkg::AXIS_X;
    if (rvalid_q) begin
      case (rstep_q)
        glc_pkg::RD_CEN: acc_ctl.cen = 1'b1;
        glc_pkg::RD_XP:  acc_ctl.first = 1'b1;
        glc_pkg::RD_XM: begin
          acc_ctl.second = 1'b1;
          acc_ctl.axis   = glc_pkg::AXIS_X;
        end
        glc_pkg::RD_YP:  acc_ctl.first = 1'b1;
        glc_pkg::RD_YM: begin
          acc_ctl.second = 1'b1;
          acc_ctl.axis   = glc_pkg::AXIS_Y;
        end
        glc_pkg::RD_ZP:  acc_ctl.first = 1'b1;
        glc_pkg::RD_ZM: begin
          acc_ctl.second = 1'b1;
          acc_ctl.axis   = glc_pkg::AXIS_Z;
          acc_ctl.last   = 1'b1;
        end
        default: acc_ctl = '0;
      endcase
    end
  end

  assign weights.wx = weight_x_q;
  assign weights.wy = weight_y_q;
  assign weights.wz = weight_z_q;

  glc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (acc_ctl),
    .rd_data_i    (rd_data),
    .weights_i    (weights),
    .done_o       (acc_done),
    .conduction_o (acc_cond)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q   <= glc_pkg::SIZE_RESET;
      size_y_q   <= glc_pkg::SIZE_RESET;
      size_z_q   <= glc_pkg::SIZE_RESET;
      weight_x_q <= glc_pkg::WEIGHT_RESET;
      weight_y_q <= glc_pkg::WEIGHT_RESET;
      weight_z_q <= glc_pkg::WEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        glc_pkg::CFG_SIZE_X:   size_x_q   <= cfg_data_i[SW-1:0];
        glc_pkg::CFG_SIZE_Y:   size_y_q   <= cfg_data_i[SW-1:0];
        glc_pkg::CFG_SIZE_Z:   size_z_q   <= cfg_data_i[SW-1:0];
        glc_pkg::CFG_WEIGHT_X: weight_x_q <= cfg_data_i;
        glc_pkg::CFG_WEIGHT_Y: weight_y_q <= cfg_data_i;
        glc_pkg::CFG_WEIGHT_Z: weight_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Query coordinates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_data_i.x_index;
      y_q <= in_data_i.y_index;
      z_q <= in_data_i.z_index;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= glc_pkg::RD_CEN;
      rstep_q     <= glc_pkg::RD_CEN;
      rvalid_q    <= 1'b0;
      clr_addr_q  <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      rvalid_q <= rd_en;
      rstep_q  <= step_q;
      // Drop the result once taken, unless a new one is loaded now
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + ADW'(1);
          if (clr_addr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_data_i.operation == glc_pkg::OP_QUERY) begin
            step_q <= glc_pkg::RD_CEN;
            if (in_range) begin
              oor_q   <= 1'b0;
              state_q <= ST_READ;
            end else begin
              oor_q   <= 1'b1;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_READ: begin
          if (step_q == glc_pkg::RD_ZM) begin
            state_q <= ST_DRAIN;
          end else begin
            step_q <= glc_pkg::rd_step_e'(step_q + 3'd1);
          end
        end
        ST_DRAIN: begin
          if (acc_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold the sum until the output register is free
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_data_q.out_of_range <= oor_q;
            out_data_q.conduction   <= oor_q ? '0 : acc_cond;
            state_q                 <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // The single RAM never writes and reads in the same cycle
  a_ram_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && rd_en))
    else $error("RAM write and read overlap");

  // A finished sum arrives only while the sequencer waits for it
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> state_q == ST_DRAIN)
    else $error("accumulator done outside drain");

  // Out-of-range results carry a zero conduction
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.out_of_range |-> out_data_q.conduction == '0)
    else $error("out-of-range result not zero");

  // No transaction is taken before the clearing pass ends
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !rd_en && !out_valid_q)
    else $error("activity during clearing pass");
`endif

endmodule

/* test/glc_conduction_checker.sv */
// ----------------------------------------------------------------------------
// glc_conduction_checker: result predictor and comparator for the grid block
// Watches the input, output and register channels, keeps a private copy of
// the temperature grid and the registers, predicts each query result and
// compares it against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module glc_conduction_checker
  import glc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int REPORT_MAX = 10;
  localparam int SUM_W      = 72;
  localparam logic signed [SUM_W-1:0] COND_HI = 72'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [SUM_W-1:0] COND_LO = -COND_HI - 72'sd1;

  logic signed [TEMP_W-1:0] grid_temp [MAX_POINTS];
  logic [SIZE_W-1:0]        size_reg [3];
  logic [WEIGHT_W-1:0]      weight_reg [3];
  out_item_t                conduction_q [$];
  out_item_t                want;
  int                       result_idx;

  // Map a size register onto the number of points actually used
  function automatic int axis_extent(input logic [SIZE_W-1:0] r);
    int n;
    n = int'(r);
    if (n < 1) n = 1;
    if (n > AXIS_MAX) n = AXIS_MAX;
    return n;
  endfunction

  function automatic int grid_slot(input int x, input int y, input int z);
    return (z * AXIS_MAX + y) * AXIS_MAX + x;
  endfunction

  function automatic logic signed [SUM_W-1:0] temp_at(input int x, input int y, input int z);
    return grid_temp[grid_slot(x, y, z)];
  endfunction

  // Negative weighted second difference over the three axes, saturated
  function automatic out_item_t predict_conduction(input in_item_t item);
    int                       ext [3];
    int                       pos [3];
    int                       hi [3];
    int                       lo [3];
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] wt;
    out_item_t                r;
    r = '0;
    pos[0] = int'(item.x_index);
    pos[1] = int'(item.y_index);
    pos[2] = int'(item.z_index);
    for (int a = 0; a < 3; a++) ext[a] = axis_extent(size_reg[a]);
    if (pos[0] >= ext[0] || pos[1] >= ext[1] || pos[2] >= ext[2]) begin
      r.out_of_range = 1'b1;
      return r;
    end
    acc = '0;
    for (int a = 0; a < 3; a++) begin
      // clamp neighbours to the edge point
      hi = pos;
      lo = pos;
      if (pos[a] + 1 < ext[a]) hi[a] = pos[a] + 1;
      if (pos[a] > 0) lo[a] = pos[a] - 1;
      diff = temp_at(hi[0], hi[1], hi[2]) + temp_at(lo[0], lo[1], lo[2])
           - temp_at(pos[0], pos[1], pos[2]) - temp_at(pos[0], pos[1], pos[2]);
      wt = $signed({40'd0, weight_reg[a]});
      acc = acc + diff * wt;
    end
    acc = -acc;
    if (acc > COND_HI) begin
      r.conduction = COND_HI[COND_W-1:0];
    end else if (acc < COND_LO) begin
      r.conduction = COND_LO[COND_W-1:0];
    end else begin
      r.conduction = acc[COND_W-1:0];
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) grid_temp[i] = '0;
      for (int a = 0; a < 3; a++) begin
        size_reg[a]   = SIZE_RESET;
        weight_reg[a] = WEIGHT_RESET;
      end
      conduction_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      result_idx   = 0;
    end else begin
      // retire one result transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (conduction_q.size() == 0) begin
          flag_error($sformatf("result %0d: unexpected, conduction %0d flag %0b",
                               result_idx, out_data_i.conduction, out_data_i.out_of_range));
        end else begin
          want = conduction_q.pop_front();
          if (out_data_i.conduction !== want.conduction ||
              out_data_i.out_of_range !== want.out_of_range) begin
            flag_error($sformatf("result %0d: expected conduction %0d flag %0b, got %0d flag %0b",
                                 result_idx, want.conduction, want.out_of_range,
                                 out_data_i.conduction, out_data_i.out_of_range));
          end
        end
        result_idx++;
      end
      // accept one input transaction
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.operation == OP_QUERY) begin
          conduction_q.push_back(predict_conduction(in_data_i));
        end else begin
          grid_temp[grid_slot(int'(in_data_i.x_index), int'(in_data_i.y_index),
                              int'(in_data_i.z_index))] = in_data_i.temperature;
        end
      end
      // track register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SIZE_X:   size_reg[0]   = cfg_data_i[SIZE_W-1:0];
          CFG_SIZE_Y:   size_reg[1]   = cfg_data_i[SIZE_W-1:0];
          CFG_SIZE_Z:   size_reg[2]   = cfg_data_i[SIZE_W-1:0];
          CFG_WEIGHT_X: weight_reg[0] = cfg_data_i[WEIGHT_W-1:0];
          CFG_WEIGHT_Y: weight_reg[1] = cfg_data_i[WEIGHT_W-1:0];
          CFG_WEIGHT_Z: weight_reg[2] = cfg_data_i[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      pending_o = conduction_q.size();
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for grid_laplacian_conduction_top
// Drives directed store and query transactions at the edges of the value
// ranges and the size registers, then random register settings and random
// transactions with idle bursts on both channels; the checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import glc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 32'h7FFFFFFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 32'h80000000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt = 0;
  int                    stall_left = 0;
  bit                    idle_on = 1'b1;
  int                    axis_len [3] = '{1, 1, 1};

  grid_laplacian_conduction_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  glc_conduction_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // End the run if the block stops answering
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Present one transaction, optionally after an idle burst, and hold it until taken
  task automatic send_item(input logic op, input int x, input int y, input int z,
                           input logic [TEMP_W-1:0] t);
    in_item_t item;
    item.operation   = op;
    item.x_index     = AXIS_W'(x);
    item.y_index     = AXIS_W'(y);
    item.z_index     = AXIS_W'(z);
    item.temperature = t;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      in_data  = in_item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write one register; track the used size for coordinate choice
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int n;
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx <= CFG_SIZE_Z) begin
      n = int'(val[SIZE_W-1:0]);
      if (n == 0) n = 1;
      if (n > AXIS_MAX) n = AXIS_MAX;
      axis_len[idx] = n;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid, wait for every prediction to be matched, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [TEMP_W-1:0] pick_temp();
    logic [TEMP_W-1:0] t;
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: t = TEMP_W'($urandom_range(0, 819200)) - TEMP_W'(409600);
      2: begin
        case ($urandom_range(0, 3))
          0: t = TEMP_MAX;
          1: t = TEMP_MIN;
          2: t = '0;
          default: t = '1;
        endcase
      end
      default: t = TEMP_W'($urandom_range(0, 2097152)) - TEMP_W'(1048576);
    endcase
    return t;
  endfunction

  initial begin
    int                    c [3];
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] s;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset sizes: a single point, neighbours clamp onto the centre
    send_item(OP_STORE, 3, 0, 0, 32'h00012345);
    send_item(OP_QUERY, 0, 0, 0, $urandom);
    send_item(OP_QUERY, 1, 0, 0, $urandom);
    drain();

    // Full grid with maximum weights: drive both saturation directions
    write_reg(CFG_SIZE_X, 32'd16);
    write_reg(CFG_SIZE_Y, 32'hFFFFFFF0);
    write_reg(CFG_SIZE_Z, 32'd16);
    write_reg(CFG_WEIGHT_X, 32'hFFFFFFFF);
    write_reg(CFG_WEIGHT_Y, 32'hFFFFFFFF);
    write_reg(CFG_WEIGHT_Z, 32'hFFFFFFFF);
    write_reg(CFG_SPARE_LO, 32'd0);
    write_reg(CFG_SPARE_HI, 32'hFFFFFFFF);
    send_item(OP_STORE, 5, 5, 5, TEMP_MAX);
    send_item(OP_STORE, 6, 5, 5, TEMP_MIN);
    send_item(OP_STORE, 4, 5, 5, TEMP_MIN);
    send_item(OP_STORE, 5, 6, 5, TEMP_MIN);
    send_item(OP_STORE, 5, 4, 5, TEMP_MIN);
    send_item(OP_STORE, 5, 5, 6, TEMP_MIN);
    send_item(OP_STORE, 5, 5, 4, TEMP_MIN);
    send_item(OP_QUERY, 5, 5, 5, '1);
    send_item(OP_STORE, 10, 10, 10, TEMP_MIN);
    send_item(OP_STORE, 11, 10, 10, TEMP_MAX);
    send_item(OP_STORE, 9, 10, 10, TEMP_MAX);
    send_item(OP_STORE, 10, 11, 10, TEMP_MAX);
    send_item(OP_STORE, 10, 9, 10, TEMP_MAX);
    send_item(OP_STORE, 10, 10, 11, TEMP_MAX);
    send_item(OP_STORE, 10, 10, 9, TEMP_MAX);
    send_item(OP_QUERY, 10, 10, 10, '0);
    // point stored while outside the old size, and the far corner
    send_item(OP_QUERY, 3, 0, 0, $urandom);
    send_item(OP_QUERY, 15, 15, 15, $urandom);
    drain();

    // Size zero counts as one, oversized clips to the axis
    write_reg(CFG_SIZE_X, 32'd0);
    write_reg(CFG_SIZE_Y, 32'd31);
    write_reg(CFG_SIZE_Z, 32'd17);
    write_reg(CFG_WEIGHT_X, 32'd0);
    write_reg(CFG_WEIGHT_Y, 32'd1);
    write_reg(CFG_WEIGHT_Z, 32'h00010000);
    send_item(OP_QUERY, 0, 5, 5, $urandom);
    send_item(OP_QUERY, 0, 10, 10, $urandom);
    send_item(OP_QUERY, 1, 0, 0, $urandom);

    // Random register settings, each followed by a burst of random transactions
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      if (phase == RAND_PHASES - 1) idle_on = 1'b0;
      for (int a = 0; a < 3; a++) begin
        s = $urandom & ~CFG_DATA_W'(31);
        if ($urandom_range(0, 7) == 0) begin
          s[SIZE_W-1:0] = ($urandom_range(0, 1) == 0) ? SIZE_W'(0) : SIZE_W'($urandom_range(17, 31));
        end else begin
          s[SIZE_W-1:0] = SIZE_W'($urandom_range(1, AXIS_MAX));
        end
        write_reg(CFG_SIZE_X + CFG_IDX_W'(a), s);
        case ($urandom_range(0, 4))
          0: w = '0;
          1: w = '1;
          2: w = WEIGHT_RESET;
          3: w = $urandom;
          default: w = CFG_DATA_W'($urandom_range(0, 32'h40000));
        endcase
        write_reg(CFG_WEIGHT_X + CFG_IDX_W'(a), w);
      end
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 1)), $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // keep most points inside the grid so queries reach the stencil
        for (int a = 0; a < 3; a++) begin
          if ($urandom_range(0, 9) != 0) c[a] = $urandom_range(0, axis_len[a] - 1);
          else c[a] = $urandom_range(0, AXIS_MAX - 1);
        end
        if ($urandom_range(0, 1) == 0) send_item(OP_STORE, c[0], c[1], c[2], pick_temp());
        else send_item(OP_QUERY, c[0], c[1], c[2], pick_temp());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/glc_pkg.sv
sv/glc_ram.sv
sv/glc_accum.sv
sv/grid_laplacian_conduction_top.sv
test/glc_conduction_checker.sv
test/tb.sv
